>>> hw/rtl/srtc_pkg.sv
// Shared types, constants and BCD helper functions for the serial RTC command interface.
// No dependencies; used by srtc_engine and serial_rtc_command_interface_top.

package srtc_pkg;

  // Command prefix carried in the top nibble of the command byte
  localparam logic [3:0] CMD_PREFIX = 4'h6;

  // Status register values and masks, and hour byte masks and flags
  localparam logic [7:0] STATUS_RESET = 8'h80;
  localparam logic [7:0] STATUS_WMASK = 8'h7F;
  localparam logic [7:0] HOUR24_MASK  = 8'h3F;
  localparam logic [7:0] HOUR12_MASK  = 8'h1F;
  localparam logic [7:0] PM_FLAG      = 8'h80;
  localparam int unsigned MODE24_BIT  = 6;

  // Register indexes decoded from command bits 3..1
  localparam logic [2:0] REG_RESET    = 3'd0;
  localparam logic [2:0] REG_STATUS   = 3'd1;
  localparam logic [2:0] REG_DATETIME = 3'd2;
  localparam logic [2:0] REG_TIME     = 3'd4;

  // Payload length in bytes per register
  localparam logic [2:0] REG_LEN [8] = '{3'd0, 3'd1, 3'd7, 3'd0, 3'd3, 3'd3, 3'd3, 3'd0};

  localparam int unsigned PAYLOAD_DEPTH = 7;

  // Commit kinds reported with each result
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_RESET    = 3'd1;
  localparam logic [2:0] KIND_DATETIME = 3'd2;
  localparam logic [2:0] KIND_TIME     = 3'd3;
  localparam logic [2:0] KIND_STATUS   = 3'd4;

  // One pin event plus the current binary date and time
  typedef struct packed {
    logic       select_rise;
    logic       select_fall;
    logic       clock_rise;
    logic       data_in;
    logic [6:0] now_year;
    logic [3:0] now_month;
    logic [4:0] now_day;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } srtc_item_t;

  // One result of a step
  typedef struct packed {
    logic       data_out;
    logic [2:0] commit_kind;
    logic [7:0] written_year;
    logic [7:0] written_month;
    logic [7:0] written_day;
    logic [5:0] written_hour;
    logic [7:0] written_minute;
    logic [7:0] written_second;
    logic [7:0] status_now;
  } srtc_result_t;

  // Binary to BCD, tens by reciprocal multiply (exact for every 7-bit input)
  function automatic logic [7:0] enc_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  // Hour to BCD in 24-hour form or 12-hour form with PM flag
  function automatic logic [7:0] enc_hour(input logic [4:0] h, input logic mode24);
    logic [4:0] h12;
    logic [7:0] pm;
    if (mode24) begin
      return enc_bcd({2'b00, h});
    end
    if (h >= 5'd24) begin
      h12 = h - 5'd24;
    end else if (h >= 5'd12) begin
      h12 = h - 5'd12;
    end else begin
      h12 = h;
    end
    if (h12 == 5'd0) begin
      h12 = 5'd12;
    end
    pm = (h >= 5'd12) ? PM_FLAG : 8'h00;
    return enc_bcd({2'b00, h12}) | pm;
  endfunction

  // BCD to binary, no digit check
  function automatic logic [7:0] dec_bcd(input logic [7:0] b);
    return 8'({4'b0000, b[7:4]} * 8'd10) + {4'b0000, b[3:0]};
  endfunction

  // Hour byte to 24-hour binary
  function automatic logic [5:0] dec_hour(input logic [7:0] hb, input logic mode24);
    logic [7:0] h;
    if (mode24) begin
      return 6'(dec_bcd(hb & HOUR24_MASK));
    end
    h = dec_bcd(hb & HOUR12_MASK);
    if (hb[7]) begin
      if (h != 8'd12) begin
        h = h + 8'd12;
      end
    end else if (h == 8'd12) begin
      h = 8'd0;
    end
    return h[5:0];
  endfunction

endpackage

>>> hw/rtl/srtc_engine.sv
// Protocol state and single-step logic of the serial RTC command interface.
// Depends on srtc_pkg; holds phase, shift, payload and status registers.

module srtc_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,   // apply item_i this cycle
  input  srtc_pkg::srtc_item_t  item_i,
  output srtc_pkg::srtc_result_t result_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_OUT   = 3'd2;
  localparam logic [2:0] PH_IN    = 3'd3;
  localparam logic [2:0] PH_STALL = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] count_q, count_d;
  logic [7:0] payload_q [srtc_pkg::PAYLOAD_DEPTH];
  logic [7:0] payload_d [srtc_pkg::PAYLOAD_DEPTH];
  logic [2:0] length_q, length_d;
  logic [2:0] byte_q, byte_d;
  logic [2:0] bit_q, bit_d;
  logic       serial_q, serial_d;
  logic [7:0] status_q, status_d;

  logic       commit_en;
  logic [2:0] commit_reg;
  logic [2:0] dec_reg;
  logic       mode24;

  assign mode24 = status_q[srtc_pkg::MODE24_BIT];

  // Next state for one pin event
  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    count_d    = count_q;
    payload_d  = payload_q;
    length_d   = length_q;
    byte_d     = byte_q;
    bit_d      = bit_q;
    serial_d   = serial_q;
    status_d   = status_q;
    commit_en  = 1'b0;
    commit_reg = srtc_pkg::REG_RESET;
    dec_reg    = shift_q[3:1];
    result_o   = '0;

    if (step_i) begin
      priority if (item_i.select_fall) begin
        phase_d  = PH_IDLE;
        shift_d  = 8'h00;
        count_d  = 4'd0;
        serial_d = 1'b0;
      end else if (item_i.select_rise) begin
        phase_d = PH_CMD;
        shift_d = 8'h00;
        count_d = 4'd0;
      end else if (item_i.clock_rise) begin
        unique case (phase_q)
          PH_CMD: begin
            shift_d = {shift_q[6:0], item_i.data_in};
            dec_reg = shift_d[3:1];
            count_d = count_q + 4'd1;
            if (count_d == 4'd8) begin
              // Decode the complete command byte
              if (shift_d[7:4] != srtc_pkg::CMD_PREFIX) begin
                phase_d = PH_STALL;
              end else begin
                length_d = srtc_pkg::REG_LEN[dec_reg];
                byte_d   = 3'd0;
                bit_d    = 3'd0;
                for (int i = 0; i < srtc_pkg::PAYLOAD_DEPTH; i++) begin
                  payload_d[i] = 8'h00;
                end
                if (length_d == 3'd0) begin
                  if (!shift_d[0]) begin
                    commit_en  = 1'b1;
                    commit_reg = dec_reg;
                  end
                  phase_d = PH_STALL;
                end else if (!shift_d[0]) begin
                  phase_d = PH_IN;
                end else begin
                  // Preload read payload
                  if (dec_reg == srtc_pkg::REG_STATUS) begin
                    payload_d[0] = status_q;
                  end else if (dec_reg == srtc_pkg::REG_DATETIME) begin
                    payload_d[0] = srtc_pkg::enc_bcd(item_i.now_year);
                    payload_d[1] = srtc_pkg::enc_bcd({3'b000, item_i.now_month});
                    payload_d[2] = srtc_pkg::enc_bcd({2'b00, item_i.now_day});
                    payload_d[3] = srtc_pkg::enc_bcd({4'b0000, item_i.now_weekday});
                    payload_d[4] = srtc_pkg::enc_hour(item_i.now_hour, mode24);
                    payload_d[5] = srtc_pkg::enc_bcd({1'b0, item_i.now_minute});
                    payload_d[6] = srtc_pkg::enc_bcd({1'b0, item_i.now_second});
                  end else if (dec_reg == srtc_pkg::REG_TIME) begin
                    payload_d[0] = srtc_pkg::enc_hour(item_i.now_hour, mode24);
                    payload_d[1] = srtc_pkg::enc_bcd({1'b0, item_i.now_minute});
                    payload_d[2] = srtc_pkg::enc_bcd({1'b0, item_i.now_second});
                  end
                  phase_d = PH_OUT;
                end
              end
            end
          end
          PH_OUT: begin
            // Drive payload LSB first, zero past the end
            if (byte_q < length_q && byte_q != 3'd7) begin
              serial_d = payload_q[byte_q][bit_q];
              bit_d    = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                byte_d = byte_q + 3'd1;
              end
            end else begin
              serial_d = 1'b0;
            end
          end
          PH_IN: begin
            // Shift payload in LSB first, commit after the last bit
            if (byte_q < length_q && byte_q != 3'd7) begin
              payload_d[byte_q][bit_q] = payload_q[byte_q][bit_q] | item_i.data_in;
              bit_d = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                byte_d = byte_q + 3'd1;
                if (byte_d == length_q) begin
                  commit_en  = 1'b1;
                  commit_reg = shift_q[3:1];
                  phase_d    = PH_STALL;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end

    // Commit a write and report it
    if (commit_en) begin
      unique case (commit_reg)
        srtc_pkg::REG_RESET: begin
          status_d             = srtc_pkg::STATUS_RESET;
          result_o.commit_kind = srtc_pkg::KIND_RESET;
        end
        srtc_pkg::REG_STATUS: begin
          status_d             = payload_d[0] & srtc_pkg::STATUS_WMASK;
          result_o.commit_kind = srtc_pkg::KIND_STATUS;
        end
        srtc_pkg::REG_DATETIME: begin
          result_o.commit_kind    = srtc_pkg::KIND_DATETIME;
          result_o.written_year   = srtc_pkg::dec_bcd(payload_d[0]);
          result_o.written_month  = srtc_pkg::dec_bcd(payload_d[1]);
          result_o.written_day    = srtc_pkg::dec_bcd(payload_d[2]);
          result_o.written_hour   = srtc_pkg::dec_hour(payload_d[4], mode24);
          result_o.written_minute = srtc_pkg::dec_bcd(payload_d[5]);
          result_o.written_second = srtc_pkg::dec_bcd(payload_d[6]);
        end
        srtc_pkg::REG_TIME: begin
          result_o.commit_kind    = srtc_pkg::KIND_TIME;
          result_o.written_hour   = srtc_pkg::dec_hour(payload_d[0], mode24);
          result_o.written_minute = srtc_pkg::dec_bcd(payload_d[1]);
          result_o.written_second = srtc_pkg::dec_bcd(payload_d[2]);
        end
        default: ;
      endcase
    end

    result_o.data_out   = serial_d;
    result_o.status_now = status_d;
  end

  // Hold state between steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      shift_q  <= 8'h00;
      count_q  <= 4'd0;
      length_q <= 3'd0;
      byte_q   <= 3'd0;
      bit_q    <= 3'd0;
      serial_q <= 1'b0;
      status_q <= srtc_pkg::STATUS_RESET;
      for (int i = 0; i < srtc_pkg::PAYLOAD_DEPTH; i++) begin
        payload_q[i] <= 8'h00;
      end
    end else begin
      phase_q   <= phase_d;
      shift_q   <= shift_d;
      count_q   <= count_d;
      length_q  <= length_d;
      byte_q    <= byte_d;
      bit_q     <= bit_d;
      serial_q  <= serial_d;
      status_q  <= status_d;
      payload_q <= payload_d;
    end
  end

  // Byte pointer never runs past the payload
  assert property (@(posedge clk_i) disable iff (!rst_ni) byte_q <= length_q)
    else $error("byte index beyond payload length");

  // Commits only come from a clock event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.commit_kind != srtc_pkg::KIND_NONE) |->
      (step_i && item_i.clock_rise && !item_i.select_fall && !item_i.select_rise))
    else $error("commit reported without a clock event");

  // Select fall returns to idle with the data line low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.select_fall) |=> (phase_q == PH_IDLE && !serial_q))
    else $error("select fall did not return to idle");

  // Status only moves on a step
  assert property (@(posedge clk_i) disable iff (!rst_ni) !step_i |=> $stable(status_q))
    else $error("status changed without a step");

endmodule

>>> hw/rtl/serial_rtc_command_interface_top.sv
// Top level of the serial RTC command interface: input register, step engine, result register.
// Depends on srtc_pkg and srtc_engine.
//
//  channel  direction  tdata (low bit up)                               tuser (low bit up)
//  s_axis   in         data_in, now_year, now_month, now_day,           select_rise,
//                      now_weekday, now_hour, now_minute, now_second    select_fall, clock_rise
//  m_axis   out        data_out, written_year, written_month,           commit_kind
//                      written_day, written_hour, written_minute,
//                      written_second, status_now
//
// One transaction in gives one transaction out; a new one is taken every cycle.
// The result passes two registers: the input register takes the transaction,
// and the step logic feeds the result register from it.
// rst_ni clears the engine state (status reads 0x80) and empties both registers.
// A stalled result register holds the step; the input register then fills and tready drops.

module serial_rtc_command_interface_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_in, now_year[6:0], now_month[3:0], now_day[4:0], now_weekday[2:0],
  // now_hour[4:0], now_minute[5:0], now_second[5:0], zero fill
  input  logic [39:0] s_axis_tdata,
  // select_rise, select_fall, clock_rise
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_out, written_year[7:0], written_month[7:0], written_day[7:0],
  // written_hour[5:0], written_minute[7:0], written_second[7:0], status_now[7:0], zero fill
  output logic [55:0] m_axis_tdata,
  // commit_kind[2:0]
  output logic [2:0]  m_axis_tuser
);

  logic                   in_valid_q;
  srtc_pkg::srtc_item_t   in_item_q;
  srtc_pkg::srtc_item_t   in_item_d;
  logic                   out_valid_q;
  srtc_pkg::srtc_result_t out_res_q;
  srtc_pkg::srtc_result_t step_res;
  logic                   step;
  logic                   in_take;

  // Step when an item waits and the result register is free or is being taken
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Unpack the incoming transaction
  always_comb begin
    in_item_d.select_rise = s_axis_tuser[0];
    in_item_d.select_fall = s_axis_tuser[1];
    in_item_d.clock_rise  = s_axis_tuser[2];
    in_item_d.data_in     = s_axis_tdata[0];
    in_item_d.now_year    = s_axis_tdata[7:1];
    in_item_d.now_month   = s_axis_tdata[11:8];
    in_item_d.now_day     = s_axis_tdata[16:12];
    in_item_d.now_weekday = s_axis_tdata[19:17];
    in_item_d.now_hour    = s_axis_tdata[24:20];
    in_item_d.now_minute  = s_axis_tdata[30:25];
    in_item_d.now_second  = s_axis_tdata[36:31];
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
  end

  srtc_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= step_res;
    end
  end

  // Pack the outgoing transaction
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.commit_kind;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.status_now,
                          out_res_q.written_second,
                          out_res_q.written_minute,
                          out_res_q.written_hour,
                          out_res_q.written_day,
                          out_res_q.written_month,
                          out_res_q.written_year,
                          out_res_q.data_out};

endmodule
